// ===== sv/rkxd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rkxd_pkg
// Shared types, constants and a function of the rolling-key XOR block decoder.
// ----------------------------------------------------------------------------
package rkxd_pkg;

    localparam int NumLanes      = 4;
    localparam int ByteW         = 8;
    localparam int CountW        = 3;
    localparam int KeyW          = NumLanes * ByteW;
    localparam int ApbAddrW      = 3;
    localparam int ApbDataW      = 32;

    typedef logic [ByteW-1:0]    t_byte;
    typedef logic [CountW-1:0]   t_count;
    typedef logic [KeyW-1:0]     t_key;

    localparam t_byte  PlainOffset = 8'h10;
    localparam t_count FullCount   = 3'd4;

    // Register index codes, taken from paddr[2].
    typedef enum logic {
        REG_INITIAL_KEY = 1'b0,
        REG_UNUSED      = 1'b1
    } t_reg_idx;

    // Control handed from the top level to the merging stage.
    typedef struct packed {
        logic   load;
        t_count valid_count;
    } t_merge_ctl;

    // Next key from the cipher block, selected by cipher byte 0 modulo 4.
    // Key byte k is c(3-k) if c0 mod 4 is 0, else c((k + c0 mod 4) mod 4).
    function automatic t_key next_key(input t_byte c0, input t_byte c1,
                                      input t_byte c2, input t_byte c3);
        t_key k;
        unique case (c0[1:0])
            2'd0:    k = {c0, c1, c2, c3};
            2'd1:    k = {c0, c3, c2, c1};
            2'd2:    k = {c1, c0, c3, c2};
            default: k = {c2, c1, c0, c3};
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

// ===== sv/rkxd_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rkxd channel interfaces
// Valid/ready channels for cipher blocks in and decoded blocks out.
// ----------------------------------------------------------------------------
interface rkxd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] cipher_byte_0;
    logic [7:0] cipher_byte_1;
    logic [7:0] cipher_byte_2;
    logic [7:0] cipher_byte_3;
    logic [2:0] byte_count;
    logic       start_of_file;

    modport source (
        output valid, cipher_byte_0, cipher_byte_1, cipher_byte_2, cipher_byte_3,
               byte_count, start_of_file,
        input  ready
    );
    modport sink (
        input  valid, cipher_byte_0, cipher_byte_1, cipher_byte_2, cipher_byte_3,
               byte_count, start_of_file,
        output ready
    );
endinterface

interface rkxd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] plain_byte_0;
    logic [7:0] plain_byte_1;
    logic [7:0] plain_byte_2;
    logic [7:0] plain_byte_3;
    logic [2:0] valid_count;

    modport source (
        output valid, plain_byte_0, plain_byte_1, plain_byte_2, plain_byte_3,
               valid_count,
        input  ready
    );
    modport sink (
        input  valid, plain_byte_0, plain_byte_1, plain_byte_2, plain_byte_3,
               valid_count,
        output ready
    );
endinterface
`default_nettype wire

// ===== sv/rkxd_apb_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rkxd_apb_regs
// APB register file holding the seed key.
// ----------------------------------------------------------------------------
module rkxd_apb_regs (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             psel,
    input  wire                             penable,
    input  wire                             pwrite,
    input  wire  [rkxd_pkg::ApbAddrW-1:0]   paddr,
    input  wire  [rkxd_pkg::ApbDataW-1:0]   pwdata,
    output logic [rkxd_pkg::ApbDataW-1:0]   prdata,
    output logic                            pready,
    output rkxd_pkg::t_key                  o_initial_key
);
    import rkxd_pkg::*;

    t_key     r_initial_key;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[2]);
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && (reg_idx == REG_INITIAL_KEY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_initial_key <= '0;
        end else if (wr_en) begin
            r_initial_key <= pwdata;
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_INITIAL_KEY: prdata = r_initial_key;
            default:         prdata = '0;
        endcase
    end

    assign o_initial_key = r_initial_key;

endmodule
`default_nettype wire

// ===== sv/rkxd_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rkxd_lane
// One byte lane: XOR with key or saved byte, add plain offset, zero if unused.
// ----------------------------------------------------------------------------
module rkxd_lane (
    input  rkxd_pkg::t_byte i_cipher,
    input  rkxd_pkg::t_byte i_key_byte,
    input  rkxd_pkg::t_byte i_prev_first,
    input  wire             i_full,
    input  wire             i_enable,
    output rkxd_pkg::t_byte o_plain
);
    import rkxd_pkg::*;

    t_byte key_sel;

    // A partial block uses the first cipher byte of the last full block, or seed key byte 0 after a start of file.
    assign key_sel = i_full ? i_key_byte : i_prev_first;
    assign o_plain = i_enable ? t_byte'((key_sel ^ i_cipher) + PlainOffset) : '0;

endmodule
`default_nettype wire

// ===== sv/rkxd_merge.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rkxd_merge
// Gathers the lane results into one output register and drives the channel.
// ----------------------------------------------------------------------------
module rkxd_merge (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  rkxd_pkg::t_merge_ctl    i_ctl,
    input  rkxd_pkg::t_byte         i_plain [rkxd_pkg::NumLanes],
    output logic                    o_can_load,
    rkxd_out_if.source              o_res
);
    import rkxd_pkg::*;

    logic   r_valid;
    t_byte  r_plain [NumLanes];
    t_count r_count;

    // The register frees up in the same cycle its transfer completes.
    assign o_can_load = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_plain <= i_plain;
            r_count <= i_ctl.valid_count;
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.plain_byte_0 = r_plain[0];
    assign o_res.plain_byte_1 = r_plain[1];
    assign o_res.plain_byte_2 = r_plain[2];
    assign o_res.plain_byte_3 = r_plain[3];
    assign o_res.valid_count  = r_count;

endmodule
`default_nettype wire

// ===== sv/rolling_key_xor_block_decoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rolling_key_xor_block_decoder
// Decodes 4-byte cipher blocks with a key that rolls from block to block.
// ----------------------------------------------------------------------------
// A block's result is registered and shows on o_res in the next cycle.
// Throughput: one block per cycle unless o_res stalls; four byte lanes decode
// in parallel and the key update is a byte permutation settled in the same
// cycle as the decode. Reset (synchronous, active low) clears the seed key,
// the rolling key, the saved first cipher byte and the output valid flag.
module rolling_key_xor_block_decoder (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             psel,
    input  wire                             penable,
    input  wire                             pwrite,
    input  wire  [rkxd_pkg::ApbAddrW-1:0]   paddr,
    input  wire  [rkxd_pkg::ApbDataW-1:0]   pwdata,
    output logic [rkxd_pkg::ApbDataW-1:0]   prdata,
    output logic                            pready,
    rkxd_in_if.sink                         i_blk,
    rkxd_out_if.source                      o_res
);
    import rkxd_pkg::*;

    t_key       initial_key;
    t_key       r_rolling_key;
    t_byte      r_prev_first;
    t_key       key_eff;
    t_byte      prev_eff;
    t_byte      cipher [NumLanes];
    t_byte      plain  [NumLanes];
    t_count     cnt;
    logic       full;
    logic       accept;
    logic       can_load;
    t_merge_ctl merge_ctl;

    rkxd_apb_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_initial_key (initial_key)
    );

    assign cipher[0] = i_blk.cipher_byte_0;
    assign cipher[1] = i_blk.cipher_byte_1;
    assign cipher[2] = i_blk.cipher_byte_2;
    assign cipher[3] = i_blk.cipher_byte_3;
    assign cnt       = i_blk.byte_count;
    assign full      = (cnt >= FullCount);

    assign i_blk.ready = can_load;
    assign accept      = i_blk.valid && can_load;

    // A start of file reloads the key before this block is decoded.
    assign key_eff  = i_blk.start_of_file ? initial_key : r_rolling_key;
    assign prev_eff = i_blk.start_of_file ? initial_key[ByteW-1:0] : r_prev_first;

    for (genvar g = 0; g < NumLanes; g++) begin : g_lane
        rkxd_lane u_lane (
            .i_cipher     (cipher[g]),
            .i_key_byte   (key_eff[g*ByteW +: ByteW]),
            .i_prev_first (prev_eff),
            .i_full       (full),
            .i_enable     (full || (cnt > t_count'(g))),
            .o_plain      (plain[g])
        );
    end

    assign merge_ctl.load        = accept;
    assign merge_ctl.valid_count = full ? FullCount : cnt;

    rkxd_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (merge_ctl),
        .i_plain    (plain),
        .o_can_load (can_load),
        .o_res      (o_res)
    );

    // Only a full block advances the key; others keep the key in effect.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rolling_key <= '0;
            r_prev_first  <= '0;
        end else if (accept) begin
            if (full) begin
                r_rolling_key <= next_key(cipher[0], cipher[1], cipher[2], cipher[3]);
                r_prev_first  <= cipher[0];
            end else begin
                r_rolling_key <= key_eff;
                r_prev_first  <= prev_eff;
            end
        end
    end

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: rolling-key XOR block decoder testbench
// Drives cipher blocks through the input channel and checks each decoded
// block against an in-bench decoder or a hand-worked result. A directed table
// covers the reset state, the byte extremes, all four key permutations and the
// partial and odd byte counts. Random files follow under several seed keys and
// different amounts of sender idling and receiver back-pressure.
// ----------------------------------------------------------------------------
module tb;
    import rkxd_pkg::*;

    localparam int CycleLimit    = 200000;
    localparam int NumPhases     = 5;
    localparam int ItemsPerPhase = 210;
    localparam int DirRows       = 23;

    // Key permutation chosen by cipher byte 0 modulo 4.
    typedef enum logic [1:0] {
        KP_REVERSE = 2'd0,
        KP_ROT1    = 2'd1,
        KP_ROT2    = 2'd2,
        KP_ROT3    = 2'd3
    } t_key_perm;

    typedef struct packed {
        logic             sof;
        t_count           cnt;
        t_byte [3:0]      c;
    } t_cipher_blk;

    typedef struct packed {
        t_count           cnt;
        t_byte [3:0]      p;
    } t_plain_blk;

    typedef struct packed {
        logic             typed;
        t_cipher_blk      blk;
        t_plain_blk       res;
    } t_dir_row;

    // Rows with typed set carry a hand-worked result; the others are predicted.
    t_dir_row dir_tab [DirRows] = '{
        '{1'b1, {1'b0, FullCount, 32'h0000_0000}, {FullCount, 32'h1010_1010}},
        '{1'b1, {1'b0, FullCount, 32'hFFFF_FFFF}, {FullCount, 32'h0F0F_0F0F}},
        '{1'b1, {1'b0, 3'd1,      32'hFFFF_FFFF}, {3'd1,      32'h0000_0010}},
        '{1'b1, {1'b0, 3'd0,      32'h1234_5678}, {3'd0,      32'h0000_0000}},
        '{1'b1, {1'b1, 3'd3,      32'hFFFF_FFFF}, {3'd3,      32'h000F_0F0F}},
        '{1'b1, {1'b1, 3'd7,      32'h0000_0000}, {FullCount, 32'h1010_1010}},
        '{1'b1, {1'b0, 3'd5,      32'hF0F0_F0F0}, {FullCount, 32'h0000_0000}},
        '{1'b1, {1'b0, 3'd6,      32'hF0F0_F0F0}, {FullCount, 32'h1010_1010}},
        '{1'b0, {1'b0, 3'd2,      32'hA1B2_C3D4}, '0},
        '{1'b0, {1'b0, FullCount, 32'h4433_2210}, '0},
        '{1'b0, {1'b0, FullCount, 32'h8877_6655}, '0},
        '{1'b0, {1'b0, FullCount, 32'hDDCC_BB01}, '0},
        '{1'b0, {1'b0, FullCount, 32'h1122_3344}, '0},
        '{1'b0, {1'b0, FullCount, 32'hA5B6_C7D2}, '0},
        '{1'b0, {1'b0, FullCount, 32'h5A6B_7C8D}, '0},
        '{1'b0, {1'b0, FullCount, 32'h0F1E_2D3B}, '0},
        '{1'b0, {1'b0, FullCount, 32'h0000_0000}, '0},
        '{1'b0, {1'b0, 3'd2,      32'hFFFF_FFFF}, '0},
        '{1'b0, {1'b0, FullCount, 32'h1357_9BDF}, '0},
        '{1'b0, {1'b1, 3'd1,      32'h0000_0080}, '0},
        '{1'b0, {1'b1, 3'd0,      32'hFFFF_FFFF}, '0},
        '{1'b0, {1'b0, FullCount, 32'h0000_0000}, '0},
        '{1'b0, {1'b0, 3'd3,      32'h7F7F_7F7F}, '0}
    };

    int ph_idle  [NumPhases] = '{0, 47, 0, 19, 0};
    int ph_stall [NumPhases] = '{0, 0, 47, 19, 0};

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ApbAddrW-1:0]  paddr;
    logic [ApbDataW-1:0]  pwdata;
    logic [ApbDataW-1:0]  prdata;
    logic                 pready;

    rkxd_in_if  blk_if ();
    rkxd_out_if res_if ();

    rolling_key_xor_block_decoder DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_blk   (blk_if),
        .o_res   (res_if)
    );

    // Decoder state as the bench sees it.
    t_key        seed_key;
    t_byte [3:0] roll_key;
    t_byte       last_c0;

    t_plain_blk  plain_q [$];
    int          err_count;
    int          cycle_cnt;
    int          idle_pct;
    int          stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_plain_blk decode_block(input t_cipher_blk b);
        t_plain_blk  r;
        t_byte [3:0] nk;
        t_key_perm   perm;
        r = '0;
        if (b.sof) begin
            roll_key = seed_key;
            last_c0  = seed_key[7:0];
        end
        if (b.cnt == 3'd0) return r;
        if (b.cnt >= FullCount) begin
            for (int k = 0; k < NumLanes; k++)
                r.p[k] = (roll_key[k] ^ b.c[k]) + PlainOffset;
            r.cnt   = FullCount;
            last_c0 = b.c[0];
            perm    = t_key_perm'(b.c[0][1:0]);
            for (int k = 0; k < NumLanes; k++) begin
                if (perm == KP_REVERSE)
                    nk[k] = b.c[3-k];
                else
                    nk[k] = b.c[(k + int'(perm)) % NumLanes];
            end
            roll_key = nk;
        end else begin
            // A partial block decodes against the saved first cipher byte
            // and leaves the key alone.
            for (int k = 0; k < NumLanes; k++)
                if (k < b.cnt) r.p[k] = (last_c0 ^ b.c[k]) + PlainOffset;
            r.cnt = b.cnt;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("ERROR at %0t: %s", $time, msg);
    endtask

    task automatic send_block(input t_cipher_blk b, input logic typed,
                              input t_plain_blk typed_res);
        t_plain_blk pred;
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            blk_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        blk_if.valid         <= 1'b1;
        blk_if.cipher_byte_0 <= b.c[0];
        blk_if.cipher_byte_1 <= b.c[1];
        blk_if.cipher_byte_2 <= b.c[2];
        blk_if.cipher_byte_3 <= b.c[3];
        blk_if.byte_count    <= b.cnt;
        blk_if.start_of_file <= b.sof;
        do @(posedge i_clk); while (!blk_if.ready);
        pred = decode_block(b);
        plain_q.push_back(typed ? typed_res : pred);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        blk_if.valid <= 1'b0;
        while (plain_q.size() != 0) @(posedge i_clk);
    endtask

    // Writes the seed key, then reads it back over the same port.
    task automatic set_seed_key(input t_key v);
        logic [ApbDataW-1:0] rd;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_INITIAL_KEY, 2'b00};
        pwdata  <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        seed_key = v;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        if (rd !== seed_key)
            report_mismatch($sformatf("seed key read back %h, wrote %h", rd, seed_key));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Receiver side: back-pressure changes at the falling edge only.
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_plain_blk got;
        t_plain_blk want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = {res_if.valid_count, res_if.plain_byte_3, res_if.plain_byte_2,
                   res_if.plain_byte_1, res_if.plain_byte_0};
            if (plain_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result transfer %h", got));
            end else begin
                want = plain_q.pop_front();
                if (got.cnt !== want.cnt)
                    report_mismatch($sformatf("valid_count %0d, want %0d",
                                              got.cnt, want.cnt));
                for (int k = 0; k < NumLanes; k++)
                    if (got.p[k] !== want.p[k])
                        report_mismatch($sformatf("plain_byte_%0d %h, want %h",
                                                  k, got.p[k], want.p[k]));
            end
        end
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CycleLimit) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        t_cipher_blk b;
        int          len;
        int          sent;

        i_rst_n   = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        blk_if.valid         = 1'b0;
        blk_if.cipher_byte_0 = '0;
        blk_if.cipher_byte_1 = '0;
        blk_if.cipher_byte_2 = '0;
        blk_if.cipher_byte_3 = '0;
        blk_if.byte_count    = '0;
        blk_if.start_of_file = 1'b0;
        err_count = 0;
        idle_pct  = 0;
        stall_pct = 0;
        seed_key  = '0;
        roll_key  = '0;
        last_c0   = '0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The directed part runs on the reset seed key of zero.
        for (int r = 0; r < DirRows; r++)
            send_block(dir_tab[r].blk, dir_tab[r].typed, dir_tab[r].res);

        for (int ph = 0; ph < NumPhases; ph++) begin
            drain_results();
            idle_pct  = ph_idle[ph];
            stall_pct = ph_stall[ph];
            if (ph == 0)
                set_seed_key('1);
            else if (ph == 1)
                set_seed_key('0);
            else
                set_seed_key($urandom());
            sent = 0;
            while (sent < ItemsPerPhase) begin
                if ($urandom_range(9) == 0) begin
                    // Noise: any flag and any count, zero and above four too.
                    b.sof = 1'($urandom_range(1));
                    b.cnt = t_count'($urandom_range(7));
                    b.c   = $urandom();
                    send_block(b, 1'b0, '0);
                    sent++;
                end else begin
                    // A file: start block, full blocks, often a partial tail.
                    len = $urandom_range(1, 12);
                    for (int j = 0; j < len; j++) begin
                        b.sof = (j == 0);
                        b.c   = $urandom();
                        b.cnt = FullCount;
                        if (j == len - 1 && $urandom_range(2) != 0)
                            b.cnt = t_count'($urandom_range(1, 3));
                        send_block(b, 1'b0, '0);
                        sent++;
                    end
                end
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
